// ===== rtl/gif_lzw_encoder_defines.svh =====
// assertion macros for the gif lzw encoder top level
`ifndef GIF_LZW_ENCODER_DEFINES_SVH
`define GIF_LZW_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
// property that holds on every clock edge out of reset
`define GLZW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("glzw assertion failed");
// antecedent this cycle implies consequent in the next cycle
`define GLZW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glzw assertion failed");
`else
`define GLZW_ASSERT(lbl, prop)
`define GLZW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/glzw_pkg.sv =====
// types and constants shared by the gif lzw encoder modules
package glzw_pkg;

  // dictionary geometry
  localparam int unsigned DictEntries = 4096;
  localparam int unsigned CodeW       = $clog2(DictEntries);
  localparam int unsigned MaxWidth    = 12;
  localparam int unsigned RootMin     = 2;
  localparam int unsigned RootMax     = 8;
  localparam int unsigned RootSpan    = 1 << RootMax;
  localparam int unsigned QueueDepth  = 2;

  // configuration port
  localparam int unsigned AddrW       = 3;
  localparam int unsigned DataW       = 32;
  localparam logic [AddrW-3:0] REG_ROOT_BITS = '0;
  localparam logic [3:0] RootBitsReset = 4'd8;

  // input opcodes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PIXEL,
    CMD_FINISH
  } cmd_kind_e;

  // classified item from the front end, root size already clamped
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] pixel;
    logic [3:0] root;
  } cmd_t;

  typedef enum logic [1:0] {
    PK_CODE,
    PK_DISCARD,
    PK_FLUSH,
    PK_END
  } pk_op_e;

  // request to the bit packer
  typedef struct packed {
    pk_op_e           op;
    logic [CodeW-1:0] code;
    logic [3:0]       width;
  } pk_cmd_t;

  // back end status seen by the top level
  typedef struct packed {
    logic           busy;
    logic [CodeW:0] next_free;
  } back_stat_t;

endpackage

// ===== rtl/glzw_front.sv =====
// configuration register, opcode classification and command queue
module glzw_front
  import glzw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [3:0]             root_bits_q;
  logic                   reg_sel;
  logic [3:0]             root_clamped;
  cmd_t                   entry;
  logic                   keep;
  logic                   push;
  logic                   pop;
  cmd_t                   fifo_q [QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q;
  logic [PtrW-1:0]        rd_ptr_q;
  logic [PtrW:0]          count_q;

  // register decode
  assign reg_sel = (paddr[AddrW-1:2] == REG_ROOT_BITS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DataW-4){1'b0}}, root_bits_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_bits_q <= RootBitsReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      root_bits_q <= pwdata[3:0];
    end
  end

  // clamp root size into the supported range
  always_comb begin
    if (root_bits_q < 4'(RootMin)) begin
      root_clamped = 4'(RootMin);
    end else if (root_bits_q > 4'(RootMax)) begin
      root_clamped = 4'(RootMax);
    end else begin
      root_clamped = root_bits_q;
    end
  end

  // classify the incoming transaction, unused opcode is dropped
  always_comb begin
    entry.pixel = in_data_i.pixel;
    entry.root  = root_clamped;
    entry.kind  = CMD_PIXEL;
    keep        = 1'b1;
    case (in_data_i.opcode)
      OP_START: begin
        entry.kind = CMD_START;
      end
      OP_PIXEL: begin
        entry.kind = CMD_PIXEL;
      end
      OP_FINISH: begin
        entry.kind = CMD_FINISH;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // command queue toward the back end
  assign in_ready_o  = (count_q != (PtrW+1)'(QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o && keep;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/glzw_back.sv =====
// dictionary walker: child list search, entry allocation and code emission
module glzw_back
  import glzw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       pk_valid_o,
  input  logic       pk_ready_i,
  output pk_cmd_t    pk_o,
  output back_stat_t stat_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_HEAD     = 4'd1;
  localparam logic [3:0] S_NODE     = 4'd2;
  localparam logic [3:0] S_MISS     = 4'd3;
  localparam logic [3:0] S_LINK     = 4'd4;
  localparam logic [3:0] S_FULL     = 4'd5;
  localparam logic [3:0] S_START    = 4'd6;
  localparam logic [3:0] S_CLR_CODE = 4'd7;
  localparam logic [3:0] S_FIN_CODE = 4'd8;
  localparam logic [3:0] S_FIN_END  = 4'd9;
  localparam logic [3:0] S_FLUSH    = 4'd10;
  localparam logic [3:0] S_END      = 4'd11;

  localparam logic [CodeW:0] NullCode = {1'b1, {CodeW{1'b0}}};
  localparam int unsigned    NodeW    = CodeW + 1 + 8;

  // dictionary storage
  logic [CodeW:0]   head_mem [DictEntries];
  logic [NodeW-1:0] node_mem [DictEntries];

  logic [3:0]          state_q, state_d;
  logic [3:0]          root_q, root_d;
  logic [CodeW:0]      nfc_q, nfc_d;
  logic [3:0]          width_q, width_d;
  logic [CodeW:0]      cur_q, cur_d;
  logic [7:0]          pix_q, pix_d;
  logic [CodeW:0]      head_q, head_d;
  logic [CodeW-1:0]    lno_q, lno_d;
  logic [RootSpan-1:0] root_vld_q;
  logic                vld_clr;

  logic                head_we, head_re;
  logic [CodeW-1:0]    head_waddr, head_raddr;
  logic [CodeW:0]      head_wdata;
  logic [CodeW:0]      head_rd_q;
  logic                head_low_q, head_vld_q;
  logic [CodeW:0]      head_val;

  logic                node_we, node_re;
  logic [CodeW-1:0]    node_waddr, node_raddr;
  logic [NodeW-1:0]    node_wdata;
  logic [NodeW-1:0]    node_rd_q;
  logic [CodeW:0]      node_sib;
  logic [7:0]          node_chr;

  logic [CodeW-1:0]    clear_code;
  logic [CodeW-1:0]    start_clear;
  logic [7:0]          pix_mask;
  logic [7:0]          pix_in;
  logic [CodeW-1:0]    slot;

  // derived codes
  assign clear_code  = {{(CodeW-1){1'b0}}, 1'b1} << root_q;
  assign start_clear = {{(CodeW-1){1'b0}}, 1'b1} << cmd_i.root;
  assign pix_mask    = 8'((9'd1 << root_q) - 9'd1);
  assign pix_in      = cmd_i.pixel & pix_mask;
  assign slot        = nfc_q[CodeW-1:0];

  // root heads that were not written since the last clear read as null
  assign head_val = (head_low_q && !head_vld_q) ? NullCode : head_rd_q;
  assign node_sib = node_rd_q[NodeW-1:8];
  assign node_chr = node_rd_q[7:0];

  // head memory, registered read
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd_q  <= head_mem[head_raddr];
      head_low_q <= (head_raddr[CodeW-1:RootMax] == '0);
      head_vld_q <= root_vld_q[head_raddr[RootMax-1:0]];
    end
  end

  // sibling link and entry character memory, registered read
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_raddr];
    end
  end

  // valid bits over the root heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_vld_q <= '0;
    end else if (vld_clr) begin
      root_vld_q <= '0;
    end else if (head_we && (head_waddr[CodeW-1:RootMax] == '0)) begin
      root_vld_q[head_waddr[RootMax-1:0]] <= 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    root_d      = root_q;
    nfc_d       = nfc_q;
    width_d     = width_q;
    cur_d       = cur_q;
    pix_d       = pix_q;
    head_d      = head_q;
    lno_d       = lno_q;
    vld_clr     = 1'b0;
    cmd_ready_o = 1'b0;
    pk_valid_o  = 1'b0;
    pk_o.op     = PK_CODE;
    pk_o.code   = cur_q[CodeW-1:0];
    pk_o.width  = width_q;
    head_we     = 1'b0;
    head_re     = 1'b0;
    head_waddr  = slot;
    head_raddr  = cur_q[CodeW-1:0];
    head_wdata  = NullCode;
    node_we     = 1'b0;
    node_re     = 1'b0;
    node_waddr  = slot;
    node_raddr  = head_val[CodeW-1:0];
    node_wdata  = {head_q, pix_q};
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_START: begin
              root_d  = cmd_i.root;
              vld_clr = 1'b1;
              nfc_d   = (CodeW+1)'(start_clear) + (CodeW+1)'(2);
              width_d = cmd_i.root + 4'd1;
              cur_d   = NullCode;
              state_d = S_START;
            end
            CMD_PIXEL: begin
              pix_d = pix_in;
              if (cur_q[CodeW]) begin
                cur_d   = (CodeW+1)'(pix_in);
                state_d = S_END;
              end else begin
                head_re = 1'b1;
                state_d = S_HEAD;
              end
            end
            CMD_FINISH: begin
              state_d = cur_q[CodeW] ? S_FIN_END : S_FIN_CODE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // head of the child list of the current code
      S_HEAD: begin
        head_d = head_val;
        if (head_val[CodeW]) begin
          state_d = S_MISS;
        end else begin
          node_re    = 1'b1;
          node_raddr = head_val[CodeW-1:0];
          lno_d      = head_val[CodeW-1:0];
          state_d    = S_NODE;
        end
      end
      // one child per cycle; the newest entry never matches
      S_NODE: begin
        if ((node_chr == pix_q) && ((CodeW+1)'(lno_q) != (nfc_q - (CodeW+1)'(1)))) begin
          cur_d   = (CodeW+1)'(lno_q);
          state_d = S_END;
        end else if (node_sib[CodeW]) begin
          state_d = S_MISS;
        end else begin
          node_re    = 1'b1;
          node_raddr = node_sib[CodeW-1:0];
          lno_d      = node_sib[CodeW-1:0];
        end
      end
      // no match: emit current code, then add an entry or restart the table
      S_MISS: begin
        pk_valid_o = 1'b1;
        if (pk_ready_i) begin
          if (nfc_q == (CodeW+1)'(DictEntries)) begin
            state_d = S_FULL;
          end else begin
            node_we = 1'b1;
            head_we = 1'b1;
            state_d = S_LINK;
          end
        end
      end
      // hook the new entry in front of the current code's children
      S_LINK: begin
        head_we    = 1'b1;
        head_waddr = cur_q[CodeW-1:0];
        head_wdata = (CodeW+1)'(slot);
        nfc_d      = nfc_q + (CodeW+1)'(1);
        if (nfc_q >= ((CodeW+1)'(1) << width_q)) begin
          width_d = width_q + 4'd1;
        end
        cur_d   = (CodeW+1)'(pix_q);
        state_d = S_END;
      end
      // table full: clear code at the current width, then reset the table
      S_FULL: begin
        pk_valid_o = 1'b1;
        pk_o.code  = clear_code;
        if (pk_ready_i) begin
          vld_clr = 1'b1;
          nfc_d   = (CodeW+1)'(clear_code) + (CodeW+1)'(2);
          width_d = root_q + 4'd1;
          cur_d   = (CodeW+1)'(pix_q);
          state_d = S_END;
        end
      end
      S_START: begin
        pk_valid_o = 1'b1;
        pk_o.op    = PK_DISCARD;
        if (pk_ready_i) begin
          state_d = S_CLR_CODE;
        end
      end
      S_CLR_CODE: begin
        pk_valid_o = 1'b1;
        pk_o.code  = clear_code;
        if (pk_ready_i) begin
          state_d = S_END;
        end
      end
      S_FIN_CODE: begin
        pk_valid_o = 1'b1;
        if (pk_ready_i) begin
          state_d = S_FIN_END;
        end
      end
      S_FIN_END: begin
        pk_valid_o = 1'b1;
        pk_o.code  = clear_code + CodeW'(1);
        if (pk_ready_i) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        pk_valid_o = 1'b1;
        pk_o.op    = PK_FLUSH;
        if (pk_ready_i) begin
          state_d = S_END;
        end
      end
      // mark the last byte of this transaction
      S_END: begin
        pk_valid_o = 1'b1;
        pk_o.op    = PK_END;
        if (pk_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      root_q  <= 4'(RootMax);
      nfc_q   <= (CodeW+1)'(RootSpan + 2);
      width_q <= 4'(RootMax + 1);
      cur_q   <= NullCode;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      nfc_q   <= nfc_d;
      width_q <= width_d;
      cur_q   <= cur_d;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    head_q <= head_d;
    lno_q  <= lno_d;
  end

  assign stat_o.busy      = (state_q != S_IDLE);
  assign stat_o.next_free = nfc_q;

endmodule

// ===== rtl/glzw_pack.sv =====
// bit packer: codes to bytes lsb first, last byte marking, output register
module glzw_pack
  import glzw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pk_valid_i,
  output logic      pk_ready_o,
  input  pk_cmd_t   pk_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AccW = 7 + MaxWidth;
  localparam int unsigned CntW = $clog2(AccW + 1);

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      held_q, held_d;
  logic            held_v_q, held_v_d;
  out_item_t       out_q;
  logic            out_v_q;
  logic            out_free;
  logic            shifting;
  logic            push;
  logic            push_last;

  function automatic logic [CodeW-1:0] code_mask(input logic [CodeW-1:0] code,
                                                 input logic [3:0]       width);
    logic [CodeW:0] m;
    m = ((CodeW+1)'(1) << width) - (CodeW+1)'(1);
    return code & m[CodeW-1:0];
  endfunction

  assign out_free = !out_v_q || out_ready_i;
  assign shifting = (cnt_q >= CntW'(8));
  assign pk_ready_o = !shifting && ((pk_i.op != PK_END) || !held_v_q || out_free);

  // one byte moves per cycle unless output is held; the newest byte waits in
  // held until its successor or the end of the transaction decides its last flag
  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    push      = 1'b0;
    push_last = 1'b0;
    if (shifting) begin
      if (!held_v_q || out_free) begin
        push     = held_v_q;
        held_d   = acc_q[7:0];
        held_v_d = 1'b1;
        acc_d    = acc_q >> 8;
        cnt_d    = cnt_q - CntW'(8);
      end
    end else if (pk_valid_i && pk_ready_o) begin
      case (pk_i.op)
        PK_CODE: begin
          acc_d = acc_q | (AccW'(code_mask(pk_i.code, pk_i.width)) << cnt_q[2:0]);
          cnt_d = cnt_q + CntW'(pk_i.width);
        end
        PK_DISCARD: begin
          acc_d = '0;
          cnt_d = '0;
        end
        PK_FLUSH: begin
          if (cnt_q != '0) begin
            cnt_d = CntW'(8);
          end
        end
        PK_END: begin
          if (held_v_q) begin
            push      = 1'b1;
            push_last = 1'b1;
            held_v_d  = 1'b0;
          end
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      held_v_q <= held_v_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // byte payload registers
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (push) begin
      out_q.out_byte    <= held_q;
      out_q.last_of_run <= push_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/gif_lzw_encoder.sv =====
// gif lzw encoder top level: front end, dictionary back end and bit packer
//
//  channel   direction  handshake                  payload
//  cfg       in/out     psel penable pwrite pready  paddr pwdata prdata (root_bits)
//  in        in         in_valid_i in_ready_o       in_data_i  (opcode, pixel)
//  out       out        out_valid_o out_ready_i     out_data_o (out_byte, last_of_run)
//
// the back end takes a pixel with no current code as a new string, else walks the
// children of the current code until one matches; on a miss it emits the code and
// adds an entry, or emits the clear code and restarts the table when it is full;
// start and finish emit their codes; the back end waits while the packer shifts
// out bytes or its output register is held, one byte leaves per cycle unless held
// a two-deep command queue lets transactions arrive while the back end works
// no clearing pass after reset: the 256 root heads carry valid bits
`include "gif_lzw_encoder_defines.svh"
module gif_lzw_encoder
  import glzw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  logic       pk_valid;
  logic       pk_ready;
  pk_cmd_t    pk_cmd;
  back_stat_t back_stat;

  // accept and classify transactions
  glzw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // dictionary search and update
  glzw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .pk_valid_o  (pk_valid),
    .pk_ready_i  (pk_ready),
    .pk_o        (pk_cmd),
    .stat_o      (back_stat)
  );

  // code packing and output register
  glzw_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pk_valid_i  (pk_valid),
    .pk_ready_o  (pk_ready),
    .pk_i        (pk_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // assertions
  `GLZW_ASSERT_NEXT(a_cmd_starts_work, cmd_valid && cmd_ready, back_stat.busy)
  `GLZW_ASSERT(a_pack_only_when_busy, !pk_valid || back_stat.busy)
  `GLZW_ASSERT(a_free_code_bound, back_stat.next_free <= (CodeW+1)'(DictEntries))

endmodule

// ===== tb/gif_lzw_encoder_tb.sv =====
// testbench for the gif lzw encoder: directed and random streams checked byte by byte
`timescale 1ns / 1ps
module gif_lzw_encoder_tb;
  import glzw_pkg::*;

  localparam logic [1:0]       OP_UNUSED    = 2'd3;
  localparam logic [12:0]      NO_CODE      = 13'h1000;
  localparam logic [AddrW-1:0] ROOT_ADDR    = {REG_ROOT_BITS, 2'b00};
  localparam int unsigned      DRAIN_CYCLES = 100;
  localparam int unsigned      MAX_BYTES    = 4;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;

  gif_lzw_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // encoder state mirrored by the predictor
  logic [12:0] dict_head    [DictEntries];
  logic [12:0] dict_sibling [DictEntries];
  logic [7:0]  dict_char    [DictEntries];
  int unsigned next_code;
  int unsigned code_bits;
  int unsigned root_size;
  logic [12:0] cur_code;
  int unsigned part_bits;
  int unsigned part_count;
  logic [3:0]  root_reg;
  int unsigned item_bytes;

  out_item_t   expected_bytes [$];
  in_item_t    pending_items  [$];

  int unsigned error_count   = 0;
  int unsigned items_taken   = 0;
  int unsigned bytes_seen    = 0;
  int unsigned settings_used = 0;
  int unsigned send_wait     = 0;
  int unsigned recv_wait     = 0;
  bit          send_burst    = 1'b0;
  bit          recv_burst    = 1'b0;

  function automatic int unsigned idle_cycles(input bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  // one byte of compressed output, at most four per transaction
  function automatic void push_byte(input logic [7:0] value);
    out_item_t rec;
    if (item_bytes < MAX_BYTES) begin
      rec.out_byte    = value;
      rec.last_of_run = 1'b0;
      expected_bytes.push_back(rec);
      item_bytes++;
    end
  endfunction

  // append a code lsb first at the current width, capped at twelve bits
  function automatic void pack_code(input int unsigned code);
    int unsigned w;
    int unsigned acc;
    int unsigned total;
    w     = (code_bits > MaxWidth) ? MaxWidth : code_bits;
    acc   = part_bits | ((code & ((1 << w) - 1)) << part_count);
    total = part_count + w;
    while (total >= 8) begin
      push_byte(acc[7:0]);
      acc   = acc >> 8;
      total = total - 8;
    end
    part_bits  = acc & 32'hFF;
    part_count = total;
  endfunction

  // expected output bytes for one accepted transaction
  function automatic void encode_item(input in_item_t item);
    int unsigned clamped;
    int unsigned steps;
    int unsigned slot;
    int unsigned i;
    logic [12:0] node;
    logic [7:0]  pix;
    logic        matched;
    out_item_t   tail;
    item_bytes = 0;
    case (item.opcode)
      OP_START: begin
        // root size is clamped and latched here
        clamped = (root_reg < RootMin) ? RootMin :
                  ((root_reg > RootMax) ? RootMax : root_reg);
        root_size = clamped;
        for (i = 0; i < (1 << clamped) + 2; i++) dict_head[i] = NO_CODE;
        next_code  = (1 << clamped) + 2;
        code_bits  = clamped + 1;
        cur_code   = NO_CODE;
        part_bits  = 0;
        part_count = 0;
        pack_code(1 << clamped);
      end
      OP_PIXEL: begin
        pix = 8'(int'(item.pixel) & ((1 << root_size) - 1));
        if (cur_code[12]) begin
          // no string yet: the pixel starts one
          cur_code = 13'(pix);
        end else begin
          // walk the children of the current string
          matched = 1'b0;
          steps   = 0;
          node    = dict_head[cur_code[11:0]];
          while (!node[12] && steps < DictEntries && !matched) begin
            if (dict_char[node[11:0]] == pix && int'(node[11:0]) != next_code - 1) begin
              cur_code = {1'b0, node[11:0]};
              matched  = 1'b1;
            end else begin
              node = dict_sibling[node[11:0]];
            end
            steps++;
          end
          if (!matched && next_code >= DictEntries) begin
            // table full: emit string and clear code, restart the dictionary
            pack_code(cur_code);
            for (i = 0; i < (1 << root_size); i++) dict_head[i] = NO_CODE;
            next_code = (1 << root_size) + 2;
            pack_code(1 << root_size);
            code_bits = root_size + 1;
            cur_code  = 13'(pix);
          end else if (!matched) begin
            // miss: emit string and add it extended by the pixel
            pack_code(cur_code);
            slot               = next_code & (DictEntries - 1);
            dict_sibling[slot] = dict_head[cur_code[11:0]];
            dict_head[slot]    = NO_CODE;
            dict_char[slot]    = pix;
            dict_head[cur_code[11:0]] = 13'(slot);
            next_code++;
            if (next_code > (1 << code_bits)) code_bits++;
            cur_code = 13'(pix);
          end
        end
      end
      OP_FINISH: begin
        // pending string, end code, then the partial byte
        if (!cur_code[12]) pack_code(cur_code);
        pack_code((1 << root_size) + 1);
        if (part_count != 0) begin
          push_byte(part_bits[7:0]);
          part_bits  = 0;
          part_count = 0;
        end
      end
      default: begin
        // unused opcode leaves everything untouched
      end
    endcase
    if (item_bytes != 0) begin
      tail             = expected_bytes.pop_back();
      tail.last_of_run = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  function automatic void queue_item(input logic [1:0] op, input logic [7:0] pix);
    in_item_t item;
    item.opcode = op;
    item.pixel  = pix;
    pending_items.push_back(item);
  endfunction

  // mostly palette colors so strings repeat, sometimes any value
  function automatic logic [7:0] stream_pixel(input logic [2:0][7:0] palette);
    if ($urandom_range(0, 9) < 7) return palette[$urandom_range(0, 2)];
    return 8'($urandom_range(0, 255));
  endfunction

  // register write followed by a read back
  task automatic set_root(input logic [3:0] value);
    logic [DataW-1:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= {{(DataW-4){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    root_reg = value;
    settings_used++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[3:0] !== value) begin
      $error("root_bits: expected %0d, actual %0d", value, readback[3:0]);
      error_count++;
    end
    @(negedge clk_i);
  endtask

  // hold off until every transaction is through and the block has settled
  task automatic wait_for_drain();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // random streams, mostly well formed with some noise and broken ones
  task automatic random_streams(input int unsigned count);
    int unsigned      made;
    int unsigned      run;
    int unsigned      k;
    int unsigned      kind;
    logic [2:0][7:0]  palette;
    made = 0;
    while (made < count) begin
      for (k = 0; k < 3; k++) palette[k] = 8'($urandom_range(0, 255));
      kind = $urandom_range(0, 9);
      run  = $urandom_range(1, 24);
      if (kind < 7) begin
        queue_item(OP_START, 8'($urandom_range(0, 255)));
        for (k = 0; k < run; k++) queue_item(OP_PIXEL, stream_pixel(palette));
        queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
        made += run + 2;
      end else if (kind == 7) begin
        // stray unused opcode and a lone start or finish
        queue_item(OP_UNUSED, 8'($urandom_range(0, 255)));
        queue_item($urandom_range(0, 1) ? OP_START : OP_FINISH, 8'($urandom_range(0, 255)));
        made += 2;
      end else if (kind == 8) begin
        // pixels carrying on the previous string without a start
        for (k = 0; k < run; k++) queue_item(OP_PIXEL, stream_pixel(palette));
        made += run;
        if ($urandom_range(0, 1)) begin
          queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
          made += 1;
        end
      end else begin
        // stream cut off before its finish
        queue_item(OP_START, 8'($urandom_range(0, 255)));
        for (k = 0; k < run; k++) queue_item(OP_PIXEL, stream_pixel(palette));
        made += run + 1;
      end
    end
  endtask

  // input driver: predicts on each accepted transaction
  always @(posedge clk_i) begin : item_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        encode_item(in_data_i);
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
          send_wait = idle_cycles(send_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor: compares each byte with the oldest expectation
  always @(posedge clk_i) begin : byte_monitor
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected output byte %02h", out_data_o.out_byte);
          error_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte,
                   out_data_o.out_byte);
            error_count++;
          end
          if (out_data_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                   out_data_o.last_of_run);
            error_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
        recv_wait = idle_cycles(recv_burst);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : clock_gen
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned j;
    int unsigned p;
    logic [3:0]  phase_roots [8];
    phase_roots = '{4'd2, 4'd8, 4'd5, 4'd3, 4'd9, 4'd6, 4'd4, 4'd1};

    // predictor reset state
    for (j = 0; j < DictEntries; j++) begin
      dict_head[j]    = NO_CODE;
      dict_sibling[j] = '0;
      dict_char[j]    = '0;
    end
    next_code  = RootSpan + 2;
    code_bits  = RootMax + 1;
    root_size  = RootMax;
    cur_code   = NO_CODE;
    part_bits  = 0;
    part_count = 0;
    root_reg   = RootBitsReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset dictionary: pixels before any start, unused opcode, pixel after finish
    queue_item(OP_PIXEL, 8'hFF);
    queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'hFF);
    queue_item(OP_UNUSED, 8'hAA);
    queue_item(OP_FINISH, 8'h55);
    queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_FINISH, 8'hFF);
    wait_for_drain();

    // root below range acts as two; a repeated pixel meets the newest entry
    set_root(4'd0);
    queue_item(OP_START, 8'h00);
    queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'h03);
    queue_item(OP_PIXEL, 8'hFC);
    queue_item(OP_PIXEL, 8'h01);
    queue_item(OP_PIXEL, 8'h02);
    queue_item(OP_FINISH, 8'h00);
    wait_for_drain();

    // root above range acts as eight; back to back starts drop the partial byte
    set_root(4'd15);
    queue_item(OP_START, 8'hFF);
    queue_item(OP_START, 8'h00);
    queue_item(OP_PIXEL, 8'h80);
    queue_item(OP_PIXEL, 8'h7F);
    queue_item(OP_PIXEL, 8'h80);
    queue_item(OP_PIXEL, 8'h7F);
    queue_item(OP_PIXEL, 8'h80);
    queue_item(OP_FINISH, 8'hFF);
    wait_for_drain();

    // random streams under several root sizes
    for (p = 0; p < 8; p++) begin
      set_root(phase_roots[p]);
      random_streams(45);
      wait_for_drain();
    end

    $display("ran %0d input transactions and checked %0d output bytes", items_taken,
             bytes_seen);
    $display("covered %0d root size settings, unused opcodes and streams without a start",
             settings_used);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
